// ----- hdl/quaternion_vector_rotation_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion vector rotation unit.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATION_UNIT_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define QVR_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define QVR_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("reset check failed");
`else
`define QVR_ASSERT_IMPL(label, clk, rstn, prop)
`define QVR_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- hdl/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths for the quaternion vector rotation unit.
// ----------------------------------------------------------------------------
`default_nettype none
package qvr_pkg;
    localparam int QUAT_WIDTH = 16;
    // Squared norm of four 16-bit codes fits in 33 bits unsigned.
    localparam int NORM_WIDTH = 33;
    // Matrix entries: 2*(a*b +/- c*d) fits in 34 bits signed.
    localparam int MAT_WIDTH  = 34;
endpackage
`default_nettype wire

// ----- hdl/quaternion_vector_rotation_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_unit
// Rotates a vector by a quaternion, dividing by the squared norm.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries one transaction per quaternion/vector pair;
// the m_ channel returns the rotated vector and a zero-quaternion flag.
// Both channels use valid/ready handshakes.
// Throughput: one transaction per cycle while m_ready is high.
// Path: from the accepting edge to m_valid a pair passes two matrix stages,
// the product stage, the row sum stage, one rounding stage, the bit-per-stage
// divider, whose depth is set by the numerator width (VEC_WIDTH+36), and
// one output stage.
// The pipeline advances as a whole: when the receiver stalls, every stage
// holds, and s_ready follows m_ready or an empty output register.
// Reset clears all valid bits and holds s_ready low; payload registers are
// not reset.
// A quaternion of all zeros gives zero outputs with zero_quat_error set.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_vector_rotation_unit_defines.svh"
module quaternion_vector_rotation_unit #(
    parameter int VEC_WIDTH = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [15:0]            s_quat_x,
    input  wire logic signed [15:0]            s_quat_y,
    input  wire logic signed [15:0]            s_quat_z,
    input  wire logic signed [15:0]            s_quat_w,
    input  wire logic signed [VEC_WIDTH-1:0]   s_vec_x,
    input  wire logic signed [VEC_WIDTH-1:0]   s_vec_y,
    input  wire logic signed [VEC_WIDTH-1:0]   s_vec_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [VEC_WIDTH-1:0]        m_rot_x,
    output logic signed [VEC_WIDTH-1:0]        m_rot_y,
    output logic signed [VEC_WIDTH-1:0]        m_rot_z,
    output logic                               m_zero_quat_error
);
    localparam int MW  = qvr_pkg::MAT_WIDTH;
    localparam int NW  = qvr_pkg::NORM_WIDTH;
    localparam int PW  = MW + VEC_WIDTH;      // one product
    localparam int SW  = PW + 2;              // sum of three products
    localparam int NUMW = SW;                 // magnitude plus rounding fits
    localparam int DEPTH = 5 + NUMW;          // stages before output register

    logic en;
    logic [DEPTH-1:0] vld_reg;
    assign en      = !m_valid || m_ready;
    assign s_ready = en && aresetn;

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // Vector delay line alongside the two matrix stages.
    logic signed [VEC_WIDTH-1:0] v1_reg [3];
    logic signed [VEC_WIDTH-1:0] v2_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg[0] <= s_vec_x; v1_reg[1] <= s_vec_y; v1_reg[2] <= s_vec_z;
            v2_reg <= v1_reg;
        end
    end

    logic signed [MW-1:0] mat [9];
    logic [NW-1:0] norm;
    qvr_matrix u_matrix (
        .aclk(aclk), .en(en), .qx(s_quat_x), .qy(s_quat_y), .qz(s_quat_z),
        .qw(s_quat_w), .mat(mat), .norm(norm)
    );

    // Stage three: nine products.
    logic signed [PW-1:0] prod_reg [9];
    logic [NW-1:0] n3_reg, n4_reg, n5_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                prod_reg[k] <= PW'(mat[k]) * PW'(v2_reg[k % 3]);
            end
            n3_reg <= norm;
        end
    end

    // Stage four: row sums.
    logic signed [SW-1:0] dot_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                dot_reg[r] <= SW'(prod_reg[3*r]) + SW'(prod_reg[3*r+1])
                              + SW'(prod_reg[3*r+2]);
            end
            n4_reg <= n3_reg;
        end
    end

    // Stage five: magnitude plus half the norm.
    logic [NUMW-1:0] num_reg [3];
    logic            neg_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                neg_reg[r] <= dot_reg[r][SW-1];
                num_reg[r] <= (dot_reg[r][SW-1] ? NUMW'(-dot_reg[r]) : NUMW'(dot_reg[r]))
                              + NUMW'(n4_reg >> 1);
            end
            n5_reg <= n4_reg;
        end
    end

    // Zero-norm flag delayed to line up with the divider output.
    logic [NUMW-1:0] zero_dly_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_dly_reg <= {zero_dly_reg[NUMW-2:0], (n5_reg == '0)};
        end
    end

    logic signed [VEC_WIDTH-1:0] quo [3];
    for (genvar r = 0; r < 3; r++) begin : g_div
        qvr_divider #(.NUM_WIDTH(NUMW), .VEC_WIDTH(VEC_WIDTH)) u_div (
            .aclk(aclk), .en(en), .num(num_reg[r]), .neg(neg_reg[r]),
            .den(n5_reg), .res(quo[r])
        );
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= vld_reg[DEPTH-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_zero_quat_error <= zero_dly_reg[NUMW-1];
            m_rot_x <= zero_dly_reg[NUMW-1] ? '0 : quo[0];
            m_rot_y <= zero_dly_reg[NUMW-1] ? '0 : quo[1];
            m_rot_z <= zero_dly_reg[NUMW-1] ? '0 : quo[2];
        end
    end

    `QVR_ASSERT_IMPL(a_stall_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `QVR_ASSERT_IMPL(a_ready_rule, aclk, aresetn, s_ready == (!m_valid || m_ready))
    `QVR_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_valid && m_zero_quat_error |-> m_rot_x == '0 && m_rot_y == '0 && m_rot_z == '0)
    `QVR_ASSERT_RST(a_reset_empty, aclk, !$past(aresetn) |-> !m_valid)
endmodule
`default_nettype wire

// ----- hdl/qvr_divider.sv -----
// ----------------------------------------------------------------------------
// qvr_divider
// Pipelined restoring divider, one quotient bit per stage, with rounding
// prepared upstream. Saturates the quotient to a signed VEC_WIDTH result.
// ----------------------------------------------------------------------------
`default_nettype none
module qvr_divider #(
    parameter int NUM_WIDTH = 84,
    parameter int VEC_WIDTH = 24
) (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic [NUM_WIDTH-1:0]               num,
    input  wire logic                               neg,
    input  wire logic [qvr_pkg::NORM_WIDTH-1:0]     den,
    output logic signed [VEC_WIDTH-1:0]             res
);
    localparam int NW = qvr_pkg::NORM_WIDTH;
    // Quotients above this width saturate anyway; keep only QW bits plus flag.
    localparam int QW = VEC_WIDTH + 1;

    logic [NUM_WIDTH-1:0] num_reg  [NUM_WIDTH+1];
    logic [NW:0]          rem_reg  [NUM_WIDTH+1];
    logic [QW-1:0]        quo_reg  [NUM_WIDTH+1];
    logic                 ovf_reg  [NUM_WIDTH+1];
    logic                 neg_reg  [NUM_WIDTH+1];
    logic [NW-1:0]        den_reg  [NUM_WIDTH+1];

    always_comb begin
        num_reg[0] = num;
        rem_reg[0] = '0;
        quo_reg[0] = '0;
        ovf_reg[0] = 1'b0;
        neg_reg[0] = neg;
        den_reg[0] = den;
    end

    // One stage per quotient bit, most significant first.
    for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_stage
        logic [NW+1:0] trial;
        logic [NW:0]   rem_next;
        logic          qbit;
        always_comb begin
            trial = {rem_reg[s], num_reg[s][NUM_WIDTH-1-s]};
            qbit  = (trial >= {2'b00, den_reg[s]});
            rem_next = qbit ? (NW+1)'(trial - {2'b00, den_reg[s]}) : trial[NW:0];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[s+1] <= num_reg[s];
                rem_reg[s+1] <= rem_next;
                quo_reg[s+1] <= {quo_reg[s][QW-2:0], qbit};
                ovf_reg[s+1] <= ovf_reg[s] | quo_reg[s][QW-1];
                neg_reg[s+1] <= neg_reg[s];
                den_reg[s+1] <= den_reg[s];
            end
        end
    end

    // Saturate and restore the sign.
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    always_comb begin
        lim = neg_reg[NUM_WIDTH] ? (QW'(1) << (VEC_WIDTH-1))
                                 : ((QW'(1) << (VEC_WIDTH-1)) - QW'(1));
        mag = (ovf_reg[NUM_WIDTH] || quo_reg[NUM_WIDTH] > lim) ? lim : quo_reg[NUM_WIDTH];
        res = neg_reg[NUM_WIDTH] ? VEC_WIDTH'(-mag) : VEC_WIDTH'(mag);
    end
endmodule
`default_nettype wire

// ----- hdl/qvr_matrix.sv -----
// ----------------------------------------------------------------------------
// qvr_matrix
// Forms the scaled rotation matrix and squared norm from the quaternion
// over two register stages: products, then sums.
// ----------------------------------------------------------------------------
`default_nettype none
module qvr_matrix (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0]  qx,
    input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0]  qy,
    input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0]  qz,
    input  wire logic signed [qvr_pkg::QUAT_WIDTH-1:0]  qw,
    output logic signed [qvr_pkg::MAT_WIDTH-1:0]        mat [9],
    output logic [qvr_pkg::NORM_WIDTH-1:0]              norm
);
    localparam int MW = qvr_pkg::MAT_WIDTH;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;

    // Stage one: the ten distinct products.
    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= qx * qx; yy_reg <= qy * qy;
            zz_reg <= qz * qz; ww_reg <= qw * qw;
            xy_reg <= qx * qy; xz_reg <= qx * qz; yz_reg <= qy * qz;
            wx_reg <= qw * qx; wy_reg <= qw * qy; wz_reg <= qw * qz;
        end
    end

    function automatic logic signed [MW-1:0] ext(input logic signed [31:0] v);
        return MW'(v);
    endfunction

    // Stage two: matrix entries and norm.
    always_ff @(posedge aclk) begin
        if (en) begin
            mat[0] <= ext(ww_reg) + ext(xx_reg) - ext(yy_reg) - ext(zz_reg);
            mat[1] <= (ext(xy_reg) - ext(wz_reg)) <<< 1;
            mat[2] <= (ext(xz_reg) + ext(wy_reg)) <<< 1;
            mat[3] <= (ext(xy_reg) + ext(wz_reg)) <<< 1;
            mat[4] <= ext(ww_reg) - ext(xx_reg) + ext(yy_reg) - ext(zz_reg);
            mat[5] <= (ext(yz_reg) - ext(wx_reg)) <<< 1;
            mat[6] <= (ext(xz_reg) - ext(wy_reg)) <<< 1;
            mat[7] <= (ext(yz_reg) + ext(wx_reg)) <<< 1;
            mat[8] <= ext(ww_reg) - ext(xx_reg) - ext(yy_reg) + ext(zz_reg);
            norm   <= qvr_pkg::NORM_WIDTH'(ext(xx_reg) + ext(yy_reg)
                                           + ext(zz_reg) + ext(ww_reg));
        end
    end
endmodule
`default_nettype wire
